FILE: design/kss_pkg.sv
`default_nettype none

package kss_pkg;

	localparam int VALUE_W = 32;
	localparam int WINDOW_W = 4;
	localparam int DEF_STORE_DEPTH = 16;

	localparam logic [0:0] REG_WINDOW = 1'b0;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic                      last_in;
	} item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] sorted_value;
		logic                      last_out;
	} result_t;

	typedef struct packed {
		logic                      valid;
		logic signed [VALUE_W-1:0] val;
	} entry_t;

	// effective entry of a cell after this cycle's pop, plus its compare result
	typedef struct packed {
		entry_t ent;
		logic   gt;
	} link_t;

	typedef struct packed {
		logic                      pop;
		logic                      ins;
		logic signed [VALUE_W-1:0] v;
	} ctl_t;

endpackage

`default_nettype wire

FILE: design/kss_cell.sv
`default_nettype none

module kss_cell (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire kss_pkg::ctl_t  ctl,
	input  wire kss_pkg::link_t left,
	input  wire kss_pkg::entry_t right,
	output kss_pkg::link_t      link,
	output kss_pkg::entry_t     held
);

	logic                              valid_q;
	logic signed [kss_pkg::VALUE_W-1:0] val_q;
	kss_pkg::entry_t                   eff;
	logic                              nxt_valid;
	logic signed [kss_pkg::VALUE_W-1:0] nxt_val;

	assign held.valid = valid_q;
	assign held.val   = val_q;

	always_comb begin
		if (ctl.pop) begin
			eff = right;
		end else begin
			eff.valid = valid_q;
			eff.val   = val_q;
		end
	end

	assign link.ent = eff;
	assign link.gt  = eff.valid && (eff.val > ctl.v);

	always_comb begin
		nxt_valid = eff.valid;
		nxt_val   = eff.val;
		if (ctl.ins) begin
			priority if (left.gt) begin
				nxt_valid = 1'b1;
				nxt_val   = left.ent.val;
			end else if (link.gt || (!eff.valid && left.ent.valid)) begin
				nxt_valid = 1'b1;
				nxt_val   = ctl.v;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop || ctl.ins) begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop || ctl.ins) begin
			val_q <= nxt_val;
		end
	end

endmodule

`default_nettype wire

FILE: design/k_sorted_stream_sorter.sv
// k-sorted stream sorter.
// item channel (item_valid/item_stall, payload item): one signed value per
// transaction, last_in marking the end of a sequence. result channel
// (result_valid/result_stall, payload result): values in ascending order,
// last_out on the final value of a sequence.
// window register (APB, address 0) sets k; the store holds up to k+1 values
// in a row of cells, smallest in cell 0. Write it only while idle.
// Throughput: one item per cycle while item_stall is low. An item that finds the store at capacity
// pops the minimum, which appears on result in the cycle after acceptance.
// After a last item the store drains one value per cycle while result is not stalled,
// with item_stall high until it is empty; the next sequence may follow at once.
// The output register frees every cycle it is empty or not stalled; while
// result_stall holds a waiting result, the row of cells freezes and
// item_stall is raised.
// Reset empties the store, clears result_valid and sets window to 0.
`default_nettype none

module k_sorted_stream_sorter #(
	parameter int STORE_DEPTH = kss_pkg::DEF_STORE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_stall,
	input  wire kss_pkg::item_t   item,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output kss_pkg::result_t      result,
	input  wire logic             psel,
	input  wire logic             penable,
	input  wire logic             pwrite,
	input  wire logic [2:0]       paddr,
	input  wire logic [31:0]      pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int CW = $clog2(STORE_DEPTH + 1);
	localparam int AW = (CW > kss_pkg::WINDOW_W + 1) ? CW : kss_pkg::WINDOW_W + 1;

	logic [kss_pkg::WINDOW_W-1:0] window_q;
	logic [CW-1:0]                count_q;
	logic                         draining_q;
	logic                         result_valid_q;
	kss_pkg::result_t             result_q;

	logic            out_free;
	logic            accept;
	logic            drain_step;
	logic            pop_needed;
	logic            final_pop;
	logic [AW-1:0]   cap;
	kss_pkg::ctl_t   ctl;

	kss_pkg::link_t  links [STORE_DEPTH];
	kss_pkg::entry_t helds [STORE_DEPTH];

	assign pready = 1'b1;
	assign prdata = (paddr[2] == kss_pkg::REG_WINDOW) ?
		{{(32 - kss_pkg::WINDOW_W){1'b0}}, window_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
		end else if (psel && penable && pwrite && paddr[2] == kss_pkg::REG_WINDOW) begin
			window_q <= pwdata[kss_pkg::WINDOW_W-1:0];
		end
	end

	assign cap        = AW'(window_q) + AW'(1);
	assign pop_needed = (count_q != '0) &&
		((AW'(count_q) >= cap) || (count_q == CW'(STORE_DEPTH)));

	assign out_free   = !result_valid_q || !result_stall;
	assign item_stall = draining_q || !out_free;
	assign accept     = item_valid && !item_stall;
	assign drain_step = draining_q && out_free;
	assign final_pop  = drain_step && (count_q == CW'(1));

	assign ctl.pop = (accept && pop_needed) || drain_step;
	assign ctl.ins = accept;
	assign ctl.v   = item.value;

	for (genvar i = 0; i < STORE_DEPTH; i++) begin : g_cell
		kss_pkg::link_t  left_in;
		kss_pkg::entry_t right_in;

		if (i == 0) begin : g_first
			// sentinel: an always-valid entry that is never greater
			assign left_in.ent.valid = 1'b1;
			assign left_in.ent.val   = '0;
			assign left_in.gt        = 1'b0;
		end else begin : g_mid
			assign left_in = links[i-1];
		end

		if (i == STORE_DEPTH - 1) begin : g_last
			assign right_in.valid = 1'b0;
			assign right_in.val   = '0;
		end else begin : g_inner
			assign right_in = helds[i+1];
		end

		kss_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.left   (left_in),
			.right  (right_in),
			.link   (links[i]),
			.held   (helds[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			draining_q <= 1'b0;
		end else begin
			count_q <= count_q + CW'(ctl.ins) - CW'(ctl.pop);
			if (accept && item.last_in) begin
				draining_q <= 1'b1;
			end else if (final_pop) begin
				draining_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= ctl.pop;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && ctl.pop) begin
			result_q.sorted_value <= helds[0].val;
			result_q.last_out     <= final_pop;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STORE_DEPTH))
		else $error("store count above depth");

	a_head_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		helds[0].valid == (count_q != '0))
		else $error("cell 0 occupancy disagrees with count");

	a_drain_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		draining_q |-> count_q != '0)
		else $error("draining with an empty store");

	a_last_ends_drain: assert property (@(posedge clk) disable iff (!arst_n)
		final_pop |=> !draining_q && count_q == '0)
		else $error("final result did not empty the store");

endmodule

`default_nettype wire

FILE: tb/sv/sorted_stream_checker.sv
`timescale 1ns / 1ps

module sorted_stream_checker #(
	parameter int DEPTH = kss_pkg::DEF_STORE_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire logic              item_stall,
	input  wire kss_pkg::item_t    item,
	input  wire logic              result_valid,
	input  wire logic              result_stall,
	input  wire kss_pkg::result_t  result,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	input  wire logic              pready,
	output int                     errors,
	output int                     pending
);

	import kss_pkg::*;

	localparam logic [2:0] WINDOW_ADDR = 3'(4 * REG_WINDOW);

	logic signed [VALUE_W-1:0] model_held [DEPTH];
	int                        model_count;
	logic [WINDOW_W-1:0]       model_window;
	result_t                   expected_sorted [$];

	function automatic logic signed [VALUE_W-1:0] pop_smallest();
		logic signed [VALUE_W-1:0] m;
		m = model_held[0];
		for (int i = 1; i < model_count; i++)
			model_held[i-1] = model_held[i];
		model_count--;
		return m;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		result_t                   want;
		result_t                   got;
		logic signed [VALUE_W-1:0] v;
		int                        slot;
		int                        cap;
		if (!arst_n) begin
			model_count = 0;
			model_window = '0;
			expected_sorted.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (result_valid && !result_stall) begin
				got = result;
				if (expected_sorted.size() == 0) begin
					$display("%0t: unexpected result, value %0d last %0b",
						$time, got.sorted_value, got.last_out);
					errors++;
				end else begin
					want = expected_sorted.pop_front();
					if (got.sorted_value !== want.sorted_value) begin
						$display("%0t: sorted_value expected %0d got %0d",
							$time, want.sorted_value, got.sorted_value);
						errors++;
					end
					if (got.last_out !== want.last_out) begin
						$display("%0t: last_out expected %0b got %0b",
							$time, want.last_out, got.last_out);
						errors++;
					end
				end
			end

			if (psel && penable && pwrite && pready && paddr == WINDOW_ADDR)
				model_window = pwdata[WINDOW_W-1:0];

			if (item_valid && !item_stall) begin
				cap = int'(model_window) + 1;
				if (cap > DEPTH)
					cap = DEPTH;
				if (model_count >= cap && model_count > 0) begin
					want.sorted_value = pop_smallest();
					want.last_out = 1'b0;
					expected_sorted.push_back(want);
				end
				v = item.value;
				slot = model_count;
				while (slot > 0 && model_held[slot-1] > v) begin
					model_held[slot] = model_held[slot-1];
					slot--;
				end
				model_held[slot] = v;
				model_count++;
				if (item.last_in) begin
					while (model_count > 0) begin
						want.sorted_value = pop_smallest();
						want.last_out = (model_count == 0);
						expected_sorted.push_back(want);
					end
				end
			end
			pending = expected_sorted.size();
		end
	end

endmodule

FILE: tb/sv/tb_k_sorted_stream_sorter.sv
`timescale 1ns / 1ps

module tb_k_sorted_stream_sorter;

	import kss_pkg::*;

	localparam logic [2:0] WINDOW_ADDR = 3'(4 * REG_WINDOW);
	localparam int HOLD_CYCLES = 120;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        item_valid;
	logic        item_stall;
	item_t       item_bus;
	logic        result_valid;
	logic        result_stall;
	result_t     result_bus;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	int mismatches;
	int pending_results;
	int random_sent;
	int tx_gap_pct;
	int rx_stall_pct;
	bit calm;
	bit long_hold;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	k_sorted_stream_sorter DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready)
	);

	sorted_stream_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item_bus),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result_bus),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.pready       (pready),
		.errors       (mismatches),
		.pending      (pending_results)
	);

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side back-pressure
	initial begin : result_pacer
		bit hold_done;
		hold_done = 1'b0;
		result_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold && !hold_done) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				result_stall <= 1'b0;
			end else if (!calm && $urandom_range(1, 100) <= rx_stall_pct) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 13)) @(negedge clk);
				result_stall <= 1'b0;
			end
		end
	end

	// entered and left at a falling edge
	task automatic send_item(input logic signed [VALUE_W-1:0] v, input logic l);
		item_t it;
		it.value = v;
		it.last_in = l;
		if (!calm && $urandom_range(1, 100) <= tx_gap_pct) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(negedge clk);
		end
		item_valid <= 1'b1;
		item_bus <= it;
		do @(posedge clk); while (item_stall);
		@(negedge clk);
	endtask

	// drain outstanding results, then write the window register
	task automatic reconfigure(input int k);
		item_valid <= 1'b0;
		do @(negedge clk); while (pending_results != 0);
		repeat (24) @(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WINDOW_ADDR;
		pwdata <= 32'(k);
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	// one sequence: mostly k-sorted, sometimes heavy on duplicates or unordered
	task automatic send_run(input int len, input int k, input bit close_it);
		logic signed [VALUE_W-1:0] vals [$];
		logic signed [VALUE_W-1:0] cur;
		logic signed [VALUE_W-1:0] t;
		int mode;
		int i;
		int j;
		mode = $urandom_range(0, 9);
		cur = $urandom;
		for (i = 0; i < len; i++) begin
			if (mode <= 5) begin
				vals.push_back(cur);
				cur = cur + 32'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 5000));
			end else if (mode <= 7) begin
				case ($urandom_range(0, 4))
					0: vals.push_back(32'sh7fff_ffff);
					1: vals.push_back(32'sh8000_0000);
					2: vals.push_back(32'sh0);
					3: vals.push_back(-32'sd1);
					default: vals.push_back(32'sd1);
				endcase
			end else begin
				vals.push_back($urandom);
			end
		end
		if (mode <= 5) begin
			i = 0;
			while (k > 0 && i < len - 1) begin
				if ($urandom_range(0, 1)) begin
					j = i + $urandom_range(1, k);
					if (j >= len)
						j = len - 1;
					t = vals[i];
					vals[i] = vals[j];
					vals[j] = t;
					i = j + 1;
				end else begin
					i++;
				end
			end
		end
		for (i = 0; i < len; i++) begin
			send_item(vals[i], close_it && i == len - 1);
			random_sent++;
		end
	endtask

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	initial begin : stimulus
		int k;
		int n_seq;
		int phase_no;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item_bus = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		calm = 1'b0;
		long_hold = 1'b0;
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		random_sent = 0;
		phase_no = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// extremes of the value field, window 0
		reconfigure(0);
		send_item(32'sh7fff_ffff, 1'b0);
		send_item(32'sh8000_0000, 1'b0);
		send_item(32'sh0, 1'b0);
		send_item(-32'sd1, 1'b0);
		send_item(32'sd1, 1'b1);

		// window lowered while the store holds more than the new capacity
		reconfigure(15);
		send_item(32'sd5, 1'b0);
		send_item(-32'sd3, 1'b0);
		send_item(32'sd5, 1'b0);
		send_item(32'sd100, 1'b0);
		send_item(-32'sd100, 1'b0);
		reconfigure(2);
		send_item(32'sd7, 1'b0);
		send_item(-32'sd50, 1'b0);
		send_item(32'sd3, 1'b0);
		send_item(32'sd42, 1'b1);

		// window raised: no output until the store reaches the new capacity
		reconfigure(1);
		send_item(32'sd10, 1'b0);
		send_item(32'sd9, 1'b0);
		reconfigure(6);
		send_item(32'sd8, 1'b0);
		send_item(32'sd11, 1'b0);
		send_item(32'sd12, 1'b0);
		send_item(32'sd20, 1'b0);
		send_item(32'sd21, 1'b0);
		send_item(-32'sd7, 1'b1);
		send_item(32'sh1234_5678, 1'b1);

		// long receiver hold with a full store
		tx_gap_pct = 0;
		rx_stall_pct = 0;
		reconfigure(15);
		long_hold = 1'b1;
		send_run(40, 15, 1'b1);

		while (random_sent < 200) begin
			case (phase_no)
				0: k = 0;
				1: k = 15;
				default: k = $urandom_range(0, 15);
			endcase
			tx_gap_pct = pick_pct();
			rx_stall_pct = pick_pct();
			reconfigure(k);
			n_seq = $urandom_range(2, 4);
			for (int s = 0; s < n_seq; s++)
				send_run($urandom_range(1, 3 * k + 6), k,
					!(s == n_seq - 1 && $urandom_range(0, 3) == 0));
			phase_no++;
		end

		calm = 1'b1;
		k = $urandom_range(0, 15);
		reconfigure(k);
		send_run(15, k, 1'b1);
		send_run(15, k, 1'b1);

		item_valid <= 1'b0;
		while (pending_results != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
